FILE: hw/rtl/trq_pkg.sv
// task ready-and-time queue: shared types and constants
// operation codes, status codes, controller command and status structs
`default_nettype none

package trq_pkg;

  localparam int OP_W   = 3;
  localparam int TASK_W = 4;
  localparam int TIME_W = 32;
  localparam int MASK_W = 16;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 3'd0,
    OP_INSERT    = 3'd1,
    OP_POP       = 3'd2,
    OP_POP_READY = 3'd3,
    OP_PEEK      = 3'd4,
    OP_COUNT     = 3'd5
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic cap;
    logic scan;
    logic prep_shr;
    logic shr;
    logic wnew;
    logic prep_shl;
    logic shl;
    logic dec;
    logic resp;
  } trq_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shr_done;
    logic shl_done;
    logic go_right;
    logic go_left;
  } trq_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/trq_dpath.sv
// task ready-and-time queue: datapath
// entry memory, scan and shift counters, captured word and result registers; uses trq_pkg
`default_nettype none

module trq_dpath
  import trq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int IDX_W       = $clog2(QUEUE_DEPTH),
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire trq_cmd_t          cmd,
  output trq_stat_t              st,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [TASK_W-1:0] in_task_id,
  input  wire logic [TIME_W-1:0] in_start_time,
  input  wire logic [MASK_W-1:0] in_ready_mask,
  input  wire logic [TIME_W-1:0] in_now_time,
  output logic                   out_found,
  output logic [TASK_W-1:0]      out_task,
  output logic [TIME_W-1:0]      out_start,
  output logic [CNT_W-1:0]       out_due_count,
  output logic [CNT_W-1:0]       out_queue_length,
  output logic [STAT_W-1:0]      out_status
);

  logic [TASK_W-1:0] mem_task [QUEUE_DEPTH];
  logic [TIME_W-1:0] mem_start [QUEUE_DEPTH];
  logic [TASK_W-1:0] rd_task_r;
  logic [TIME_W-1:0] rd_start_r;

  op_t               op_r;
  logic [TASK_W-1:0] task_r;
  logic [TIME_W-1:0] start_r;
  logic [MASK_W-1:0] ready_r;
  logic [TIME_W-1:0] now_r;
  logic              full_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  pidx_r, pidx_nxt;
  logic              pend_r, pend_nxt;
  logic              hit_r, hit_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  due_r, due_nxt;
  logic [TASK_W-1:0] res_task_r, res_task_nxt;
  logic [TIME_W-1:0] res_start_r, res_start_nxt;

  logic              is_add, is_take, need_scan, match, stop, issue;
  logic [IDX_W-1:0]  raddr, waddr;
  logic              we;
  logic [TASK_W-1:0] wtask;
  logic [TIME_W-1:0] wstart;

  assign is_add    = (op_r == OP_PUSH) || (op_r == OP_INSERT);
  assign is_take   = (op_r == OP_POP) || (op_r == OP_POP_READY) || (op_r == OP_PEEK);
  assign need_scan = (op_r == OP_INSERT) || is_take || (op_r == OP_COUNT);

  always_comb begin
    case (op_r)
      OP_INSERT:            match = start_r < rd_start_r;
      OP_POP_READY:         match = ready_r[rd_task_r];
      OP_POP, OP_PEEK:      match = 1'b1;
      default:              match = 1'b0;
    endcase
  end

  assign stop = hit_r || (pend_r && match);

  always_comb begin
    st           = '0;
    st.scan_done = !pend_r && (hit_r || (idx_r == count_r) || !need_scan);
    st.shr_done  = !pend_r && (idx_r == pos_r);
    st.shl_done  = !pend_r && (idx_r == count_r);
    st.go_right  = is_add && !full_r;
    st.go_left   = hit_r && ((op_r == OP_POP) || (op_r == OP_POP_READY));
  end

  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pidx_nxt      = pidx_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    pos_nxt       = pos_r;
    due_nxt       = due_r;
    res_task_nxt  = res_task_r;
    res_start_nxt = res_start_r;
    issue         = 1'b0;
    raddr         = idx_r[IDX_W-1:0];
    we            = 1'b0;
    waddr         = pidx_r[IDX_W-1:0];
    wtask         = rd_task_r;
    wstart        = rd_start_r;

    if (cmd.cap) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
      hit_nxt  = 1'b0;
      pos_nxt  = count_r;
      due_nxt  = '0;
    end

    if (cmd.scan) begin
      issue    = need_scan && !stop && (idx_r != count_r);
      pend_nxt = issue;
      pidx_nxt = idx_r;
      if (issue) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
      if (pend_r && match && !hit_r) begin
        hit_nxt       = 1'b1;
        pos_nxt       = pidx_r;
        res_task_nxt  = rd_task_r;
        res_start_nxt = rd_start_r;
      end
      if (pend_r && (op_r == OP_COUNT) && (rd_start_r < now_r)) begin
        due_nxt = due_r + CNT_W'(1);
      end
    end

    if (cmd.prep_shr) begin
      idx_nxt  = count_r;
      pend_nxt = 1'b0;
    end

    // move entries up by one, from the tail down to the insert slot
    if (cmd.shr) begin
      issue    = idx_r != pos_r;
      pend_nxt = issue;
      pidx_nxt = idx_r;
      raddr    = IDX_W'(idx_r - CNT_W'(1));
      if (issue) begin
        idx_nxt = idx_r - CNT_W'(1);
      end
      we = pend_r;
    end

    if (cmd.wnew) begin
      we        = 1'b1;
      waddr     = pos_r[IDX_W-1:0];
      wtask     = task_r;
      wstart    = start_r;
      count_nxt = count_r + CNT_W'(1);
    end

    if (cmd.prep_shl) begin
      idx_nxt  = pos_r + CNT_W'(1);
      pend_nxt = 1'b0;
    end

    // move entries down by one over the removed slot
    if (cmd.shl) begin
      issue    = idx_r != count_r;
      pend_nxt = issue;
      pidx_nxt = idx_r - CNT_W'(1);
      if (issue) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
      we = pend_r;
    end

    if (cmd.dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_task[waddr]  <= wtask;
      mem_start[waddr] <= wstart;
    end
    rd_task_r  <= mem_task[raddr];
    rd_start_r <= mem_start[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pidx_r      <= pidx_nxt;
    pos_r       <= pos_nxt;
    due_r       <= due_nxt;
    res_task_r  <= res_task_nxt;
    res_start_r <= res_start_nxt;
    if (cmd.cap) begin
      op_r    <= op_t'(in_operation);
      task_r  <= in_task_id;
      start_r <= in_start_time;
      ready_r <= in_ready_mask;
      now_r   <= in_now_time;
      full_r  <= count_r == CNT_W'(QUEUE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_found        <= hit_r && is_take;
      out_task         <= (hit_r && is_take) ? res_task_r : '0;
      out_start        <= (hit_r && is_take) ? res_start_r : '0;
      out_due_count    <= (op_r == OP_COUNT) ? due_r : '0;
      out_queue_length <= count_r;
      if (is_add && full_r) begin
        out_status <= ST_FULL;
      end else if (is_take && !hit_r) begin
        out_status <= ST_EMPTY;
      end else begin
        out_status <= ST_OK;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(st.go_right && st.go_left))
    else $error("both shift directions requested");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !we)
    else $error("entry write during scan");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/trq_ctrl.sv
// task ready-and-time queue: controller state machine
// sequences capture, scan, shifts and result load; uses trq_pkg
`default_nettype none

module trq_ctrl
  import trq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire trq_stat_t st,
  output trq_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_SHR  = 6'b000100,
    S_WNEW = 6'b001000,
    S_SHL  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          if (st.go_right) begin
            cmd.prep_shr = 1'b1;
            state_nxt    = S_SHR;
          end else if (st.go_left) begin
            cmd.prep_shl = 1'b1;
            state_nxt    = S_SHL;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SHR: begin
        cmd.shr = 1'b1;
        if (st.shr_done) begin
          state_nxt = S_WNEW;
        end
      end
      S_WNEW: begin
        cmd.wnew  = 1'b1;
        state_nxt = S_RESP;
      end
      S_SHL: begin
        cmd.shl = 1'b1;
        if (st.shl_done) begin
          cmd.dec   = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.resp      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_SCAN))
    else $error("accepted word did not start a scan");

  a_valid_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response state");

  a_right_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && st.scan_done && st.go_right) |=> (state_r == S_SHR))
    else $error("add did not enter right shift");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/task_ready_and_time_queue_top.sv
// task ready-and-time queue: top level
// joins trq_ctrl and trq_dpath; uses trq_pkg
//
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   operation, task_id, start_time, ready_mask, now_time
// out_      output     out_valid / out_stall found, task, start, due_count, queue_length, status
//
// one word at a time: a capture step, then the scan, which reads no entry on an empty queue
// or for push, else reads entries in order and stops at the first match
// an add or remove then shifts one entry per cycle; an add then writes its new entry,
// and the result register is loaded last, where the result may wait under out_stall
// reset clears only the entry count and control state, no clearing pass
// a new word is taken while the previous result still waits under out_stall
`default_nettype none

module task_ready_and_time_queue_top
  import trq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [OP_W-1:0]                    in_operation,
  input  wire logic [TASK_W-1:0]                  in_task_id,
  input  wire logic [TIME_W-1:0]                  in_start_time,
  input  wire logic [MASK_W-1:0]                  in_ready_mask,
  input  wire logic [TIME_W-1:0]                  in_now_time,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_found,
  output logic [TASK_W-1:0]                       out_task,
  output logic [TIME_W-1:0]                       out_start,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]      out_due_count,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]      out_queue_length,
  output logic [STAT_W-1:0]                       out_status
);

  trq_cmd_t  cmd;
  trq_stat_t st;

  trq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  trq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_operation     (in_operation),
    .in_task_id       (in_task_id),
    .in_start_time    (in_start_time),
    .in_ready_mask    (in_ready_mask),
    .in_now_time      (in_now_time),
    .out_found        (out_found),
    .out_task         (out_task),
    .out_start        (out_start),
    .out_due_count    (out_due_count),
    .out_queue_length (out_queue_length),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench for the task ready-and-time queue: directed words, then random add/remove runs
// predicts every reply with its own model of the ordered queue and checks each field
// depends on trq_pkg and task_ready_and_time_queue_top
module testbench;
  import trq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int RANDOM_WORDS = 600;
  localparam int TAIL_CYCLES  = 2 * QUEUE_DEPTH + 10;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] tid;
    logic [TIME_W-1:0] start;
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] now;
    bit                drain_first;
  } sched_req_t;

  typedef struct packed {
    logic              found;
    logic [TASK_W-1:0] tid;
    logic [TIME_W-1:0] start;
    logic [CNT_W-1:0]  due;
    logic [CNT_W-1:0]  len;
    logic [STAT_W-1:0] status;
  } sched_reply_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation;
  logic [TASK_W-1:0]   in_task_id;
  logic [TIME_W-1:0]   in_start_time;
  logic [MASK_W-1:0]   in_ready_mask;
  logic [TIME_W-1:0]   in_now_time;
  logic                out_valid;
  logic                out_stall;
  logic                out_found;
  logic [TASK_W-1:0]   out_task;
  logic [TIME_W-1:0]   out_start;
  logic [CNT_W-1:0]    out_due_count;
  logic [CNT_W-1:0]    out_queue_length;
  logic [STAT_W-1:0]   out_status;

  sched_req_t   pending_words[$];
  sched_reply_t replies_owed[$];
  sched_req_t   word_on_bus;
  logic         word_taken;

  logic [TASK_W-1:0] held_task[$];
  logic [TIME_W-1:0] held_start[$];

  int words_sent;
  int replies_seen;
  int mismatches;
  int full_refusals;
  int empty_replies;
  int peak_length;

  task_ready_and_time_queue_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_task_id       (in_task_id),
    .in_start_time    (in_start_time),
    .in_ready_mask    (in_ready_mask),
    .in_now_time      (in_now_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_task         (out_task),
    .out_start        (out_start),
    .out_due_count    (out_due_count),
    .out_queue_length (out_queue_length),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  function automatic sched_reply_t run_sched_op(sched_req_t r);
    sched_reply_t res;
    int           pos;
    int           i;
    res = '0;
    case (r.op)
      OP_PUSH, OP_INSERT: begin
        if (held_task.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          pos = held_task.size();
          if (r.op == OP_INSERT) begin
            for (i = 0; i < held_task.size(); i++)
              if (pos == held_task.size() && r.start < held_start[i]) pos = i;
          end
          held_task.insert(pos, r.tid);
          held_start.insert(pos, r.start);
        end
      end
      OP_POP, OP_POP_READY, OP_PEEK: begin
        pos = held_task.size();
        if (r.op == OP_POP_READY) begin
          for (i = 0; i < held_task.size(); i++)
            if (pos == held_task.size() && r.mask[held_task[i]]) pos = i;
        end else if (held_task.size() > 0) begin
          pos = 0;
        end
        if (pos < held_task.size()) begin
          res.found = 1'b1;
          res.tid   = held_task[pos];
          res.start = held_start[pos];
          if (r.op != OP_PEEK) begin
            held_task.delete(pos);
            held_start.delete(pos);
          end
        end else begin
          res.status = ST_EMPTY;
        end
      end
      OP_COUNT: begin
        for (i = 0; i < held_task.size(); i++)
          if (held_start[i] < r.now) res.due = res.due + CNT_W'(1);
      end
      default: ;
    endcase
    res.len = CNT_W'(held_task.size());
    return res;
  endfunction

  function automatic sched_req_t make_word(logic [OP_W-1:0] op, logic [TASK_W-1:0] tid,
                                           logic [TIME_W-1:0] start, logic [MASK_W-1:0] mask,
                                           logic [TIME_W-1:0] now);
    sched_req_t w;
    w = '0;
    w.op    = op;
    w.tid   = tid;
    w.start = start;
    w.mask  = mask;
    w.now   = now;
    return w;
  endfunction

  // mix of full-range, tied small values and values near the top
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(3))
      0:       return $urandom_range(15);
      1:       return 32'hFFFF_FFF0 + $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  function automatic sched_req_t random_word(bit filling);
    sched_req_t w;
    int         roll;
    w = '0;
    roll = $urandom_range(99);
    if (roll < (filling ? 55 : 20)) begin
      w.op = ($urandom_range(1) == 1) ? OP_INSERT : OP_PUSH;
    end else begin
      case ($urandom_range(3))
        0:       w.op = OP_POP;
        1:       w.op = OP_POP_READY;
        2:       w.op = OP_PEEK;
        default: w.op = OP_COUNT;
      endcase
    end
    w.tid   = TASK_W'($urandom_range(15));
    w.start = pick_time();
    w.now   = pick_time();
    case ($urandom_range(3))
      0:       w.mask = 16'h1 << $urandom_range(15);
      1:       w.mask = MASK_W'($urandom_range(65535) & $urandom_range(65535));
      default: w.mask = MASK_W'($urandom_range(65535));
    endcase
    return w;
  endfunction

  task automatic check_reply(sched_reply_t want);
    if (out_found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, out_found);
      mismatches++;
    end
    if (out_task !== want.tid) begin
      $error("task: expected %0d, got %0d", want.tid, out_task);
      mismatches++;
    end
    if (out_start !== want.start) begin
      $error("start: expected %0h, got %0h", want.start, out_start);
      mismatches++;
    end
    if (out_due_count !== want.due) begin
      $error("due_count: expected %0d, got %0d", want.due, out_due_count);
      mismatches++;
    end
    if (out_queue_length !== want.len) begin
      $error("queue_length: expected %0d, got %0d", want.len, out_queue_length);
      mismatches++;
    end
    if (out_status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, out_status);
      mismatches++;
    end
  endtask

  // no random idling on either side in this window
  function automatic bit quiet_window();
    return words_sent >= 250 && words_sent < 400;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || word_taken) begin
        if (pending_words.size() != 0
            && !(pending_words[0].drain_first && replies_owed.size() != 0)
            && (quiet_window() || $urandom_range(99) >= 23)) begin
          word_on_bus   <= pending_words[0];
          in_operation  <= pending_words[0].op;
          in_task_id    <= pending_words[0].tid;
          in_start_time <= pending_words[0].start;
          in_ready_mask <= pending_words[0].mask;
          in_now_time   <= pending_words[0].now;
          in_valid      <= 1'b1;
          void'(pending_words.pop_front());
          words_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !quiet_window() && $urandom_range(99) < 23;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_owed.size() == 0) begin
          $error("reply with nothing owed: task %0d start %0h status %0d",
                 out_task, out_start, out_status);
          mismatches++;
        end else begin
          check_reply(replies_owed.pop_front());
        end
        replies_seen++;
        if (out_status == ST_FULL) full_refusals++;
        if (out_status == ST_EMPTY) empty_replies++;
        if (int'(out_queue_length) > peak_length) peak_length = int'(out_queue_length);
      end
      word_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) replies_owed.push_back(run_sched_op(word_on_bus));
    end
  end

  initial begin
    sched_req_t w;
    int         i;
    int         n;
    int         run_len;
    bit         filling;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    out_stall     = 1'b0;
    in_operation  = '0;
    in_task_id    = '0;
    in_start_time = '0;
    in_ready_mask = '0;
    in_now_time   = '0;
    word_on_bus   = '0;
    word_taken    = 1'b0;
    words_sent    = 0;
    replies_seen  = 0;
    mismatches    = 0;
    full_refusals = 0;
    empty_replies = 0;
    peak_length   = 0;

    // empty queue cases and spare codes
    pending_words.push_back(make_word(OP_POP, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_PEEK, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_POP_READY, 0, 0, 16'hFFFF, 0));
    pending_words.push_back(make_word(OP_COUNT, 0, 0, 0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_SPARE_LO, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_SPARE_HI, 4'hF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    // fill to the top with extremes and ties
    for (i = 0; i < QUEUE_DEPTH; i++) begin
      case (i % 4)
        0:       w = make_word(OP_PUSH, TASK_W'(i), 32'h0, 0, 0);
        1:       w = make_word(OP_INSERT, TASK_W'(i), 32'hFFFF_FFFF, 0, 0);
        2:       w = make_word(OP_PUSH, TASK_W'(i), 32'h8000_0000, 0, 0);
        default: w = make_word(OP_INSERT, TASK_W'(i), 32'h8000_0000, 0, 0);
      endcase
      pending_words.push_back(w);
    end
    pending_words.push_back(make_word(OP_PUSH, 4'hF, 32'h1234_5678, 0, 0));
    pending_words.push_back(make_word(OP_INSERT, 4'h0, 32'h0, 0, 0));
    pending_words.push_back(make_word(OP_COUNT, 0, 0, 0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(OP_COUNT, 0, 0, 0, 32'h0));
    pending_words.push_back(make_word(OP_POP_READY, 0, 0, 16'h0000, 0));
    pending_words.push_back(make_word(OP_POP_READY, 0, 0, 16'h8000, 0));
    pending_words.push_back(make_word(OP_PEEK, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_POP, 0, 0, 0, 0));

    // random runs that alternately fill and drain the queue
    n = 0;
    filling = 1'b1;
    while (n < RANDOM_WORDS) begin
      run_len = $urandom_range(60, 20);
      for (i = 0; i < run_len && n < RANDOM_WORDS; i++) begin
        w = random_word(filling);
        w.drain_first = (n % 150 == 0);
        pending_words.push_back(w);
        n++;
      end
      filling = !filling;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid || replies_owed.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d replies checked, peak queue length %0d",
             words_sent, replies_seen, peak_length);
    $display("%0d adds refused on a full queue, %0d empty replies",
             full_refusals, empty_replies);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/trq_pkg.sv
hw/rtl/trq_dpath.sv
hw/rtl/trq_ctrl.sv
hw/rtl/task_ready_and_time_queue_top.sv
tb/sv/testbench.sv
